// ----- src/evp_pkg.sv -----
// ============================================================================
// evp_pkg: shared types, constants and microcode for the velocity PID block
// Field widths, register indexes, control word layout and the sequencer
// program that drives the datapath.
// ============================================================================
package evp_pkg;

    // Default number of fraction bits for all fixed-point quantities.
    localparam int FRACTION_BITS_DEF = 8;

    // Field widths.
    localparam int TGT_W  = 16;   // target velocity and motor power
    localparam int CNT_W  = 31;   // encoder count
    localparam int TIME_W = 32;   // microsecond timestamp
    localparam int MEAS_W = 24;   // measured velocity and control error
    localparam int ACC_W  = 32;   // error accumulator
    localparam int GAIN_W = 16;   // gains, deadband, counts per inch, scale
    localparam int MINI_W = 20;   // minimum interval

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CPI          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd6;

    localparam logic [GAIN_W-1:0] RST_GAIN_P   = 16'd192;
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = 16'd51;
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = 16'd64;
    localparam logic [GAIN_W-1:0] RST_DEADBAND = 16'd0;
    localparam logic [GAIN_W-1:0] RST_CPI      = 16'd8638;
    localparam logic [GAIN_W-1:0] RST_SCALE    = 16'd1495;
    localparam logic [MINI_W-1:0] RST_MIN_INT  = 20'd1000;

    // Datapath widths.
    localparam int MAG_W      = 51;      // |delta| * 10^6
    localparam int DEN_W      = 48;      // counts_per_inch * interval
    localparam int Q_W        = MEAS_W;  // quotient bits produced by the divider
    localparam int MUL_B_W    = 21;      // signed B operand of the shared multiplier
    localparam int PID_SUM_W  = 52;      // target + P + I + D before saturation
    localparam int MILLION    = 1000000;
    localparam int PERCENT_FULL = 100;

    // Sequencer.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] S_CLEAR = 5'd17;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_PREP,
        OP_DEN,
        OP_MAG,
        OP_DIV_START,
        OP_MEAS,
        OP_ERR,
        OP_ACC,
        OP_ADD,
        OP_SAT_SUM,
        OP_POWER,
        OP_COMMIT,
        OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        A_ABS_DELTA,
        A_INTERVAL,
        A_ERR,
        A_ACC,
        A_DIFF,
        A_SUM
    } t_asel;

    typedef enum logic [2:0] {
        B_MILLION,
        B_CPI,
        B_GAIN_P,
        B_GAIN_I,
        B_GAIN_D,
        B_SCALE
    } t_bsel;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_BR_CLEAR,
        C_WAIT_DIV,
        C_WAIT_OUT
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_asel             a_sel;
        t_bsel             b_sel;
        logic              mul_en;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_op   op;
        t_asel a_sel;
        t_bsel b_sel;
        logic  mul_en;
        logic  fire;
    } t_ctrl;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic clear_item;
        logic div_busy;
        logic out_free;
    } t_status;

    // Microcode program. Each step is one control word.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w.op     = OP_NOP;
        w.a_sel  = A_ABS_DELTA;
        w.b_sel  = B_MILLION;
        w.mul_en = 1'b0;
        w.cond   = C_NEXT;
        w.target = S_IDLE;
        case (step)
            5'd0: begin
                w.op   = OP_LOAD;
                w.cond = C_WAIT_IN;
            end
            5'd1: begin
                w.op     = OP_PREP;
                w.cond   = C_BR_CLEAR;
                w.target = S_CLEAR;
            end
            5'd2: begin
                w.a_sel  = A_INTERVAL;
                w.b_sel  = B_CPI;
                w.mul_en = 1'b1;
            end
            5'd3: begin
                w.op     = OP_DEN;
                w.a_sel  = A_ABS_DELTA;
                w.b_sel  = B_MILLION;
                w.mul_en = 1'b1;
            end
            5'd4: begin
                w.op = OP_MAG;
            end
            5'd5: begin
                w.op = OP_DIV_START;
            end
            5'd6: begin
                w.cond = C_WAIT_DIV;
            end
            5'd7: begin
                w.op = OP_MEAS;
            end
            5'd8: begin
                w.op = OP_ERR;
            end
            5'd9: begin
                w.op     = OP_ACC;
                w.a_sel  = A_ERR;
                w.b_sel  = B_GAIN_P;
                w.mul_en = 1'b1;
            end
            5'd10: begin
                w.op     = OP_ADD;
                w.a_sel  = A_ACC;
                w.b_sel  = B_GAIN_I;
                w.mul_en = 1'b1;
            end
            5'd11: begin
                w.op     = OP_ADD;
                w.a_sel  = A_DIFF;
                w.b_sel  = B_GAIN_D;
                w.mul_en = 1'b1;
            end
            5'd12: begin
                w.op = OP_ADD;
            end
            5'd13: begin
                w.op = OP_SAT_SUM;
            end
            5'd14: begin
                w.a_sel  = A_SUM;
                w.b_sel  = B_SCALE;
                w.mul_en = 1'b1;
            end
            5'd15: begin
                w.op = OP_POWER;
            end
            5'd16: begin
                w.op     = OP_COMMIT;
                w.cond   = C_WAIT_OUT;
                w.target = S_IDLE;
            end
            5'd17: begin
                w.op     = OP_CLEAR;
                w.cond   = C_WAIT_OUT;
                w.target = S_IDLE;
            end
            default: begin
                w.cond   = C_JUMP;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- src/encoder_velocity_pid_top.sv -----
// ============================================================================
// encoder_velocity_pid_top: velocity PID loop with feedforward for one wheel
// Flow: an accepted control beat walks the control store, waits on the
//   divider and writes its result to the output register before the next beat
//   is taken; a reset beat branches to the clear step and gives a zero result.
// Reset: synchronous, active low; registers return to their defaults and
//   the history is cleared.
// ============================================================================
//
// The block measures wheel speed from the encoder count and timestamp that
// changed since the previous beat, forms the error against the target and
// produces a motor power from the target plus the P, I and D terms.
//
// Structure: a small control store (in the package) holds one control word
// per step. The sequencer walks it with a step counter and waits on the input
// channel, the divider and the output register. The datapath has one shared
// signed multiplier with a registered product, the PID sum accumulator, a
// restoring divider and the output register.
//
// The output register decouples the result from the downstream side: a
// finished result waits there while the sequencer goes back to take the next
// input beat, and it only stalls when a second result is ready before the
// first has been taken.
//
// Configuration writes are always accepted; they are expected only while the
// block is idle. A write to an index beyond the register list is dropped.
module encoder_velocity_pid_top
    import evp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // Configuration write channel.
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,

    // Input channel.
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_operation,
    input  logic signed [TGT_W-1:0]  i_target_velocity,
    input  logic [CNT_W-1:0]         i_encoder_count,
    input  logic [TIME_W-1:0]        i_timestamp_us,

    // Result channel.
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [TGT_W-1:0]  o_motor_power,
    output logic signed [MEAS_W-1:0] o_measured_velocity,
    output logic signed [MEAS_W-1:0] o_control_error,
    output logic                     o_power_saturated
);

    t_ctrl   ctrl;
    t_status status;

    // Registers are plain flops, so a write beat is always accepted.
    assign o_cfg_ready = 1'b1;

    evp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    evp_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl),
        .o_status            (status),
        .i_cfg_valid         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_operation         (i_operation),
        .i_target_velocity   (i_target_velocity),
        .i_encoder_count     (i_encoder_count),
        .i_timestamp_us      (i_timestamp_us),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_motor_power       (o_motor_power),
        .o_measured_velocity (o_measured_velocity),
        .o_control_error     (o_control_error),
        .o_power_saturated   (o_power_saturated)
    );

endmodule

// ----- src/evp_div.sv -----
// ============================================================================
// evp_div: radix-2 restoring divider for the velocity measurement
// Computes floor(num * 2^SHIFT / den) one quotient bit per cycle and flags
// quotients that do not fit in Q_W bits.
// ============================================================================
module evp_div
    import evp_pkg::*;
#(
    parameter int SHIFT = 2 * FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [Q_W-1:0]   o_quot,
    output logic             o_ovf
);

    localparam int NUM_W   = MAG_W + SHIFT;
    localparam int HI_W    = NUM_W - Q_W;
    localparam int CMP_W   = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int DCNT_W  = $clog2(Q_W + 1);

    logic [NUM_W-1:0]  num_full;
    logic [HI_W-1:0]   num_hi;
    logic              ovf_now;
    logic [DEN_W:0]    trial;
    logic              take;

    logic [DCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_low;
    logic [Q_W-1:0]    r_quot;
    logic              r_ovf;

    // The quotient fits in Q_W bits exactly when the part of the numerator
    // above the low Q_W bits is already smaller than the divisor.
    assign num_full = {i_num, {SHIFT{1'b0}}};
    assign num_hi   = num_full[NUM_W-1:Q_W];
    assign ovf_now  = CMP_W'(num_hi) >= CMP_W'(i_den);

    // The divisor is held steady by the datapath for the whole division.
    assign trial = {r_rem, r_low[Q_W-1]};
    assign take  = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(Q_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DEN_W'(num_hi);
            r_low  <= num_full[Q_W-1:0];
            r_quot <= '0;
            r_ovf  <= ovf_now;
        end else if (r_cnt != '0) begin
            r_rem  <= take ? DEN_W'(trial - {1'b0, i_den}) : DEN_W'(trial);
            r_low  <= {r_low[Q_W-2:0], 1'b0};
            r_quot <= {r_quot[Q_W-2:0], take};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

// ----- src/evp_dp.sv -----
// ============================================================================
// evp_dp: datapath of the velocity PID block
// Configuration and history registers, one shared multiplier, the PID sum
// accumulator, the divider and the output register, all driven by the
// sequencer's control word.
// ============================================================================
module evp_dp
    import evp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    output t_status                  o_status,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_operation,
    input  logic signed [TGT_W-1:0]  i_target_velocity,
    input  logic [CNT_W-1:0]         i_encoder_count,
    input  logic [TIME_W-1:0]        i_timestamp_us,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [TGT_W-1:0]  o_motor_power,
    output logic signed [MEAS_W-1:0] o_measured_velocity,
    output logic signed [MEAS_W-1:0] o_control_error,
    output logic                     o_power_saturated
);

    localparam int SUM_W      = FRACTION_BITS + 18;
    localparam int MUL_A_W    = (SUM_W > 33) ? SUM_W : 33;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int LIMIT_FULL = PERCENT_FULL << FRACTION_BITS;
    localparam int POWER_MAX  = (1 << (TGT_W - 1)) - 1;
    localparam int LIMIT      = (LIMIT_FULL > POWER_MAX) ? POWER_MAX : LIMIT_FULL;
    localparam logic signed [MUL_P_W-1:0] LIMIT_POS = MUL_P_W'(LIMIT);
    localparam logic signed [MUL_P_W-1:0] LIMIT_NEG = -LIMIT_POS;

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d, r_deadband, r_cpi, r_scale;
    logic [MINI_W-1:0] r_min_int;

    // History.
    logic signed [MEAS_W-1:0] r_prev_err;
    logic [CNT_W-1:0]         r_prev_count;
    logic [TIME_W-1:0]        r_prev_time;
    logic signed [ACC_W-1:0]  r_acc;

    // Current item and working registers.
    logic                        r_op;
    logic signed [TGT_W-1:0]     r_target;
    logic [CNT_W-1:0]            r_count;
    logic [TIME_W-1:0]           r_now;
    logic [TIME_W-1:0]           r_interval;
    logic                        r_neg;
    logic [CNT_W-1:0]            r_abs_delta;
    logic [DEN_W-1:0]            r_den;
    logic [MAG_W-1:0]            r_mag;
    logic signed [MEAS_W-1:0]    r_meas;
    logic signed [MEAS_W-1:0]    r_err;
    logic signed [PID_SUM_W-1:0] r_sum;
    logic signed [MUL_P_W-1:0]   r_prod;
    logic signed [TGT_W-1:0]     r_power;
    logic                        r_pow_sat;

    // Output register.
    logic                     r_out_valid;
    logic signed [TGT_W-1:0]  r_out_power;
    logic signed [MEAS_W-1:0] r_out_meas;
    logic signed [MEAS_W-1:0] r_out_err;
    logic                     r_out_sat;

    // Combinational values.
    logic [TIME_W-1:0]           elapsed;
    logic [MINI_W-1:0]           floor_us;
    logic [GAIN_W-1:0]           cpi_eff;
    logic signed [CNT_W:0]       delta;
    logic signed [MEAS_W:0]      err_diff;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic signed [MUL_P_W-1:0]   prod_shift;
    logic signed [PID_SUM_W-1:0] term;
    logic                        capped;
    logic signed [MEAS_W-1:0]    n_meas;
    logic signed [MEAS_W:0]      err_wide;
    logic signed [MEAS_W-1:0]    err_sat;
    logic [MEAS_W-1:0]           err_mag;
    logic signed [MEAS_W-1:0]    n_err;
    logic signed [ACC_W:0]       acc_wide;
    logic signed [ACC_W-1:0]     n_acc;
    logic                        sum_fits;
    logic [SUM_W-1:0]            sum_sat;
    logic                        div_busy;
    logic [Q_W-1:0]              div_quot;
    logic                        div_ovf;
    logic                        out_free;

    // Interval and count difference.
    assign elapsed  = r_now - r_prev_time;
    assign floor_us = (r_min_int == '0) ? MINI_W'(1) : r_min_int;
    assign cpi_eff  = (r_cpi == '0) ? GAIN_W'(1) : r_cpi;
    assign delta    = $signed({1'b0, r_count}) - $signed({1'b0, r_prev_count});
    assign err_diff = (MEAS_W + 1)'(r_err) - (MEAS_W + 1)'(r_prev_err);

    // Shared multiplier operand selection.
    always_comb begin
        case (i_ctrl.a_sel)
            A_ABS_DELTA: mul_a = MUL_A_W'($signed({1'b0, r_abs_delta}));
            A_INTERVAL:  mul_a = MUL_A_W'($signed({1'b0, r_interval}));
            A_ERR:       mul_a = MUL_A_W'(r_err);
            A_ACC:       mul_a = MUL_A_W'(r_acc);
            A_DIFF:      mul_a = MUL_A_W'(err_diff);
            A_SUM:       mul_a = MUL_A_W'(r_sum);
            default:     mul_a = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.b_sel)
            B_MILLION: mul_b = MUL_B_W'(MILLION);
            B_CPI:     mul_b = MUL_B_W'($signed({1'b0, cpi_eff}));
            B_GAIN_P:  mul_b = MUL_B_W'($signed({1'b0, r_gain_p}));
            B_GAIN_I:  mul_b = MUL_B_W'($signed({1'b0, r_gain_i}));
            B_GAIN_D:  mul_b = MUL_B_W'($signed({1'b0, r_gain_d}));
            B_SCALE:   mul_b = MUL_B_W'($signed({1'b0, r_scale}));
            default:   mul_b = '0;
        endcase
    end

    assign mul_p      = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign prod_shift = r_prod >>> FRACTION_BITS;
    assign term       = PID_SUM_W'(prod_shift);

    // Measured velocity: the magnitude saturates at 2^23 and the positive
    // side then folds to the largest 24-bit value.
    always_comb begin
        capped = div_ovf | div_quot[Q_W-1];
        if (r_neg) begin
            n_meas = capped ? {1'b1, {(MEAS_W-1){1'b0}}} : ('0 - div_quot);
        end else begin
            n_meas = capped ? {1'b0, {(MEAS_W-1){1'b1}}} : div_quot;
        end
    end

    // Error with 24-bit saturation and deadband.
    always_comb begin
        err_wide = (MEAS_W + 1)'(r_target) - (MEAS_W + 1)'(r_meas);
        if (err_wide[MEAS_W] == err_wide[MEAS_W-1]) begin
            err_sat = err_wide[MEAS_W-1:0];
        end else begin
            err_sat = {err_wide[MEAS_W], {(MEAS_W-1){~err_wide[MEAS_W]}}};
        end
        err_mag = err_sat[MEAS_W-1] ? ('0 - err_sat) : err_sat;
        n_err   = (err_mag < MEAS_W'(r_deadband)) ? '0 : err_sat;
    end

    // Accumulator with 32-bit saturation.
    always_comb begin
        acc_wide = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(r_err);
        if (acc_wide[ACC_W] == acc_wide[ACC_W-1]) begin
            n_acc = acc_wide[ACC_W-1:0];
        end else begin
            n_acc = {acc_wide[ACC_W], {(ACC_W-1){~acc_wide[ACC_W]}}};
        end
    end

    // The PID sum is squeezed into SUM_W bits before scaling. Any sum that
    // large clamps the power anyway, with the same sign.
    always_comb begin
        sum_fits = (&r_sum[PID_SUM_W-1:SUM_W-1]) | ~(|r_sum[PID_SUM_W-1:SUM_W-1]);
        if (sum_fits) begin
            sum_sat = r_sum[SUM_W-1:0];
        end else begin
            sum_sat = {r_sum[PID_SUM_W-1], {(SUM_W-1){~r_sum[PID_SUM_W-1]}}};
        end
    end

    evp_div #(
        .SHIFT (2 * FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.op == OP_DIV_START),
        .i_num   (r_mag),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    assign out_free = ~r_out_valid | i_out_ready;

    // Configuration and history registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= RST_GAIN_P;
            r_gain_i     <= RST_GAIN_I;
            r_gain_d     <= RST_GAIN_D;
            r_deadband   <= RST_DEADBAND;
            r_cpi        <= RST_CPI;
            r_scale      <= RST_SCALE;
            r_min_int    <= RST_MIN_INT;
            r_prev_err   <= '0;
            r_prev_count <= '0;
            r_prev_time  <= '0;
            r_acc        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GAIN_P:       r_gain_p   <= i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:       r_gain_i   <= i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:       r_gain_d   <= i_cfg_data[GAIN_W-1:0];
                    REG_DEADBAND:     r_deadband <= i_cfg_data[GAIN_W-1:0];
                    REG_CPI:          r_cpi      <= i_cfg_data[GAIN_W-1:0];
                    REG_SCALE:        r_scale    <= i_cfg_data[GAIN_W-1:0];
                    REG_MIN_INTERVAL: r_min_int  <= i_cfg_data[MINI_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_ctrl.op == OP_ACC) begin
                r_acc <= n_acc;
            end

            if (i_ctrl.fire && (i_ctrl.op == OP_COMMIT)) begin
                r_prev_err   <= r_err;
                r_prev_count <= r_count;
                r_prev_time  <= r_now;
            end else if (i_ctrl.fire && (i_ctrl.op == OP_CLEAR)) begin
                r_prev_err   <= '0;
                r_prev_count <= '0;
                r_prev_time  <= r_now;
                r_acc        <= '0;
            end

            if (i_ctrl.fire && ((i_ctrl.op == OP_COMMIT) || (i_ctrl.op == OP_CLEAR))) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output payload.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= mul_p;
        end

        case (i_ctrl.op)
            OP_LOAD: begin
                if (i_ctrl.fire) begin
                    r_op     <= i_operation;
                    r_target <= i_target_velocity;
                    r_count  <= i_encoder_count;
                    r_now    <= i_timestamp_us;
                end
            end
            OP_PREP: begin
                r_interval  <= (elapsed < TIME_W'(floor_us)) ? TIME_W'(floor_us) : elapsed;
                r_neg       <= delta[CNT_W];
                r_abs_delta <= delta[CNT_W] ? CNT_W'(-delta) : CNT_W'(delta);
            end
            OP_DEN: begin
                r_den <= DEN_W'(r_prod);
            end
            OP_MAG: begin
                r_mag <= MAG_W'(r_prod);
            end
            OP_MEAS: begin
                r_meas <= n_meas;
            end
            OP_ERR: begin
                r_err <= n_err;
            end
            OP_ACC: begin
                r_sum <= PID_SUM_W'(r_target);
            end
            OP_ADD: begin
                r_sum <= r_sum + term;
            end
            OP_SAT_SUM: begin
                r_sum <= PID_SUM_W'($signed(sum_sat));
            end
            OP_POWER: begin
                if (prod_shift > LIMIT_POS) begin
                    r_power   <= TGT_W'(LIMIT_POS);
                    r_pow_sat <= 1'b1;
                end else if (prod_shift < LIMIT_NEG) begin
                    r_power   <= TGT_W'(LIMIT_NEG);
                    r_pow_sat <= 1'b1;
                end else begin
                    r_power   <= TGT_W'(prod_shift);
                    r_pow_sat <= 1'b0;
                end
            end
            OP_COMMIT: begin
                if (i_ctrl.fire) begin
                    r_out_power <= r_power;
                    r_out_meas  <= r_meas;
                    r_out_err   <= r_err;
                    r_out_sat   <= r_pow_sat;
                end
            end
            OP_CLEAR: begin
                if (i_ctrl.fire) begin
                    r_out_power <= '0;
                    r_out_meas  <= '0;
                    r_out_err   <= '0;
                    r_out_sat   <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status.clear_item = r_op;
    assign o_status.div_busy   = div_busy;
    assign o_status.out_free   = out_free;

    assign o_out_valid         = r_out_valid;
    assign o_motor_power       = r_out_power;
    assign o_measured_velocity = r_out_meas;
    assign o_control_error     = r_out_err;
    assign o_power_saturated   = r_out_sat;

endmodule

// ----- src/evp_seq.sv -----
// ============================================================================
// evp_seq: microcode sequencer
// Step counter over the control store, with waits on the input, the divider
// and the output register, and a branch for reset items.
// ============================================================================
module evp_seq
    import evp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            word;
    logic              fire;

    assign word = ucode(r_step);

    always_comb begin
        n_step = r_step + 1'b1;
        fire   = 1'b1;
        case (word.cond)
            C_NEXT: begin
            end
            C_JUMP: begin
                n_step = word.target;
            end
            C_WAIT_IN: begin
                fire = i_in_valid;
                if (!i_in_valid) begin
                    n_step = r_step;
                end
            end
            C_BR_CLEAR: begin
                if (i_status.clear_item) begin
                    n_step = word.target;
                end
            end
            C_WAIT_DIV: begin
                if (i_status.div_busy) begin
                    n_step = r_step;
                end
            end
            C_WAIT_OUT: begin
                fire   = i_status.out_free;
                n_step = i_status.out_free ? word.target : r_step;
            end
            default: begin
                n_step = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready    = (word.cond == C_WAIT_IN);
    assign o_ctrl.op     = word.op;
    assign o_ctrl.a_sel  = word.a_sel;
    assign o_ctrl.b_sel  = word.b_sel;
    assign o_ctrl.mul_en = word.mul_en;
    assign o_ctrl.fire   = fire;

endmodule
